// ===== rtl/core/mse_pkg.sv =====
`default_nettype none

package mse_pkg;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_PASS  = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/mse_ram.sv =====
`default_nettype none

module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

// ===== rtl/core/merge_sort_engine.sv =====
`default_nettype none

// Block sorter for signed values. Elements stream in one per cycle until a
// transaction with tlast; elements past MAX_ELEMENTS are dropped and the block is then
// emitted with tuser (overflow) set on every result. The block of n elements is
// sorted ascending and stably by a bottom-up merge between two ping-pong RAMs:
// ceil(log2 n) passes, each a set-up state (ST_PASS) and then the merge of every
// pair of runs, where one shared compare unit writes one element per cycle while
// both read ports of the source RAM follow the heads of the left and right runs.
// Results then leave one per cycle while out_tready is high, tlast on the final
// one; in_tready is low from the tlast transaction until the last result is taken.
module merge_sort_engine
  import mse_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64,
  parameter int DATA_WIDTH   = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     in_tdata,   // value
  input  wire logic                                in_tlast,   // last_in
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [((DATA_WIDTH+7)/8)*8-1:0]     out_tdata,  // sorted_value
  output logic                                     out_tlast,  // last_out
  output logic                                     out_tuser   // overflow
);

  localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int AW      = $clog2(MAX_ELEMENTS);
  localparam int CW      = $clog2(MAX_ELEMENTS + 1);
  localparam int WW      = CW + 1;
  localparam int SW      = CW + 3;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic            sel_r, sel_nxt;
  logic [WW-1:0]   w_r, w_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   mid_r, mid_nxt;
  logic [CW-1:0]   hi_r, hi_nxt;

  logic                  we_a, we_b;
  logic [AW-1:0]         waddr_a;
  logic [DATA_WIDTH-1:0] wdata_a;
  logic [DATA_WIDTH-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
  logic [DATA_WIDTH-1:0] src0, src1, merge_data;

  logic          in_acc, out_acc;
  logic          take_left;
  logic [CW-1:0] base;
  logic [SW-1:0] sum_mid, sum_hi;
  logic [CW-1:0] mid_n, hi_n;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  assign src0 = sel_r ? b_rd0 : a_rd0;
  assign src1 = sel_r ? b_rd1 : a_rd1;

  // shared compare unit, left run wins ties
  assign take_left = (i_r < mid_r) &&
                     (!(j_r < hi_r) || ($signed(src0) <= $signed(src1)));
  assign merge_data = take_left ? src0 : src1;

  // bounds of the next pair of runs
  assign base    = (state_r == ST_PASS) ? '0 : hi_r;
  assign sum_mid = SW'(base) + SW'(w_r);
  assign sum_hi  = SW'(base) + SW'({w_r, 1'b0});
  assign mid_n   = (sum_mid < SW'(cnt_r)) ? CW'(sum_mid) : cnt_r;
  assign hi_n    = (sum_hi < SW'(cnt_r)) ? CW'(sum_hi) : cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    sel_nxt   = sel_r;
    w_nxt     = w_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    case (state_r)
      ST_LOAD: begin
        i_nxt = '0;
        if (in_acc) begin
          if (cnt_r < CW'(MAX_ELEMENTS)) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = ST_PASS;
            w_nxt     = WW'(1);
            sel_nxt   = 1'b0;
          end
        end
      end
      ST_PASS: begin
        i_nxt = '0;
        if (WW'(cnt_r) <= w_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_MERGE;
          j_nxt     = mid_n;
          k_nxt     = '0;
          mid_nxt   = mid_n;
          hi_nxt    = hi_n;
        end
      end
      ST_MERGE: begin
        i_nxt = i_r + CW'(take_left);
        j_nxt = j_r + CW'(!take_left);
        k_nxt = k_r + CW'(1);
        if (k_r + CW'(1) == hi_r) begin
          if (hi_r == cnt_r) begin
            state_nxt = ST_PASS;
            w_nxt     = {w_r[WW-2:0], 1'b0};
            sel_nxt   = !sel_r;
          end else begin
            i_nxt   = hi_r;
            j_nxt   = mid_n;
            mid_nxt = mid_n;
            hi_nxt  = hi_n;
          end
        end
      end
      ST_EMIT: begin
        i_nxt = i_r + CW'(out_acc);
        if (out_acc && (i_r + CW'(1) == cnt_r)) begin
          state_nxt = ST_LOAD;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          i_nxt     = '0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      sel_r   <= 1'b0;
      w_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      mid_r   <= '0;
      hi_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      sel_r   <= sel_nxt;
      w_r     <= w_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      mid_r   <= mid_nxt;
      hi_r    <= hi_nxt;
    end
  end

  assign we_a    = (in_acc && (cnt_r < CW'(MAX_ELEMENTS))) ||
                   ((state_r == ST_MERGE) && sel_r);
  assign we_b    = (state_r == ST_MERGE) && !sel_r;
  assign waddr_a = (state_r == ST_LOAD) ? cnt_r[AW-1:0] : k_r[AW-1:0];
  assign wdata_a = (state_r == ST_LOAD) ? in_tdata[DATA_WIDTH-1:0] : merge_data;

  mse_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_ELEMENTS)
  ) u_ram_a (
    .clk    (clk),
    .we     (we_a),
    .waddr  (waddr_a),
    .wdata  (wdata_a),
    .raddr0 (i_nxt[AW-1:0]),
    .raddr1 (j_nxt[AW-1:0]),
    .rdata0 (a_rd0),
    .rdata1 (a_rd1)
  );

  mse_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_ELEMENTS)
  ) u_ram_b (
    .clk    (clk),
    .we     (we_b),
    .waddr  (k_r[AW-1:0]),
    .wdata  (merge_data),
    .raddr0 (i_nxt[AW-1:0]),
    .raddr1 (j_nxt[AW-1:0]),
    .rdata0 (b_rd0),
    .rdata1 (b_rd1)
  );

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = TDATA_W'(src0);
  assign out_tlast  = (i_r + CW'(1) == cnt_r);
  assign out_tuser  = ovf_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output phases overlap");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_merge_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (k_r == i_r + (j_r - mid_r)))
    else $error("merge output index out of step with run heads");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (cnt_r == CW'(MAX_ELEMENTS)))
    else $error("overflow flagged on a block that is not full");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (cnt_r != '0))
    else $error("block ended with no stored element");

endmodule

`default_nettype wire

// ===== test/merge_sort_checker.sv =====
`timescale 1ns / 100ps

module merge_sort_checker #(
  parameter int DW  = 32,
  parameter int CAP = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  input  wire logic                        in_tready,
  input  wire logic [((DW+7)/8)*8-1:0]     in_tdata,   // value
  input  wire logic                        in_tlast,   // last_in
  input  wire logic                        out_tvalid,
  input  wire logic                        out_tready,
  input  wire logic [((DW+7)/8)*8-1:0]     out_tdata,  // sorted_value
  input  wire logic                        out_tlast,  // last_out
  input  wire logic                        out_tuser,  // overflow
  output int                               err_count,
  output int                               pending,
  output int                               result_count
);

  typedef struct packed {
    logic [DW-1:0] value;
    logic          last;
    logic          ovf;
  } sorted_elem_t;

  logic signed [DW-1:0] block_vals [CAP];
  int                   block_len;
  logic                 block_dropped;
  sorted_elem_t         sorted_q [$];

  // stable ascending order on signed values
  function automatic void queue_sorted_block();
    logic signed [DW-1:0] run [CAP];
    logic signed [DW-1:0] key;
    int                   j;
    sorted_elem_t         e;
    for (int i = 0; i < block_len; i++) run[i] = block_vals[i];
    for (int i = 1; i < block_len; i++) begin
      key = run[i];
      j = i - 1;
      while (j >= 0 && run[j] > key) begin
        run[j + 1] = run[j];
        j--;
      end
      run[j + 1] = key;
    end
    for (int i = 0; i < block_len; i++) begin
      e.value = run[i];
      e.last  = (i == block_len - 1);
      e.ovf   = block_dropped;
      sorted_q.push_back(e);
    end
  endfunction

  always @(posedge clk) begin : monitor
    sorted_elem_t got;
    sorted_elem_t want;
    if (!rst_n) begin
      block_len     = 0;
      block_dropped = 1'b0;
      sorted_q.delete();
      err_count     = 0;
      pending       = 0;
      result_count  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (block_len < CAP) begin
          block_vals[block_len] = in_tdata[DW-1:0];
          block_len++;
        end else begin
          block_dropped = 1'b1;
        end
        if (in_tlast) begin
          queue_sorted_block();
          block_len     = 0;
          block_dropped = 1'b0;
        end
      end
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[DW-1:0];
        got.last  = out_tlast;
        got.ovf   = out_tuser;
        result_count++;
        if (sorted_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: unexpected result value=%0d last=%b ovf=%b", $realtime,
                     $signed(got.value), got.last, got.ovf);
        end else begin
          want = sorted_q.pop_front();
          if (got.value !== want.value || got.last !== want.last || got.ovf !== want.ovf)
          begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: result %0d exp value=%0d last=%b ovf=%b got value=%0d last=%b ovf=%b",
                       $realtime, result_count, $signed(want.value), want.last, want.ovf,
                       $signed(got.value), got.last, got.ovf);
          end
        end
      end
      pending = sorted_q.size();
    end
  end

endmodule

// ===== test/merge_sort_engine_tb.sv =====
`timescale 1ns / 100ps

module merge_sort_engine_tb;

  localparam int DW          = 32;
  localparam int CAP         = 64;
  localparam int TDW         = ((DW + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ELEMS = 100;

  logic           clk        = 1'b0;
  logic           rst_n      = 1'b0;
  logic           in_tvalid  = 1'b0;
  logic           in_tready;
  logic [TDW-1:0] in_tdata   = '0;
  logic           in_tlast   = 1'b0;
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [TDW-1:0] out_tdata;
  logic           out_tlast;
  logic           out_tuser;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int cycles       = 0;
  int blocks_sent  = 0;
  int ovf_blocks   = 0;
  int elems_sent   = 0;
  int err_count;
  int pending;
  int result_count;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  merge_sort_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  merge_sort_checker #(
    .DW  (DW),
    .CAP (CAP)
  ) sort_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .err_count    (err_count),
    .pending      (pending),
    .result_count (result_count)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_elem(input logic [DW-1:0] value, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    elems_sent++;
    if (last) blocks_sent++;
  endtask

  function automatic logic [DW-1:0] rand_elem();
    case ($urandom_range(3))
      0: return $urandom_range(6) - 3;
      1: begin
        case ($urandom_range(3))
          0: return {1'b0, {(DW-1){1'b1}}};
          1: return {1'b1, {(DW-1){1'b0}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(9))
      0: return CAP;
      1: return CAP + $urandom_range(1, 6);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  task automatic send_block(input int len);
    for (int k = 0; k < len; k++) send_elem(rand_elem(), k == len - 1);
    if (len > CAP) ovf_blocks++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int ph;
    int sz;
    int phase_elems;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-element blocks at both extremes
    send_elem({1'b0, {(DW-1){1'b1}}}, 1'b1);
    send_elem({1'b1, {(DW-1){1'b0}}}, 1'b1);
    // mixed signs with both extremes
    send_elem(32'd0, 1'b0);
    send_elem(32'hffff_ffff, 1'b0);
    send_elem(32'd1, 1'b0);
    send_elem(32'h8000_0000, 1'b0);
    send_elem(32'h7fff_ffff, 1'b0);
    send_elem(32'hffff_ffff, 1'b0);
    send_elem(32'd0, 1'b0);
    send_elem(32'd5, 1'b1);
    // two elements in reverse order
    send_elem(32'h7fff_ffff, 1'b0);
    send_elem(32'h8000_0000, 1'b1);
    // equal keys
    send_elem(32'd3, 1'b0);
    send_elem(32'd3, 1'b0);
    send_elem(32'hffff_fffd, 1'b0);
    send_elem(32'd3, 1'b0);
    send_elem(32'hffff_fffd, 1'b1);
    wait_drained();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 80;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 80;
        end
        default: begin
          tx_idle_pct  = 24;
          rx_stall_pct = 24;
        end
      endcase
      // full block first, past capacity on odd phases
      sz = (ph % 2 == 0) ? CAP : CAP + $urandom_range(1, 6);
      phase_elems = 0;
      while (phase_elems < PHASE_ELEMS) begin
        send_block(sz);
        phase_elems += sz;
        sz = pick_size();
        // keep each phase near its element budget
        if (sz > PHASE_ELEMS - phase_elems) sz = PHASE_ELEMS - phase_elems;
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    $display("sent %0d elements in %0d blocks (%0d past capacity) under four flow phases",
             elems_sent, blocks_sent, ovf_blocks);
    $display("checked %0d sorted results in %0d cycles, %0d errors",
             result_count, cycles, err_count);
    if (err_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mse_pkg.sv
rtl/core/mse_ram.sv
rtl/core/merge_sort_engine.sv
test/merge_sort_checker.sv
test/merge_sort_engine_tb.sv
